[hw/rtl/lmbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lmbp_pkg;

  localparam int PIX_W         = 24;
  localparam int PAIR_W        = 2 * PIX_W;
  localparam int COLS          = 4;
  localparam int OVL_W         = 4;
  localparam int OVLS_W        = COLS * OVL_W;
  localparam int PAL_DEPTH     = 16;
  localparam int PAL_AW        = $clog2(PAL_DEPTH);
  localparam int ROW_W         = 5;
  localparam int ROW_SPAN      = 1 << ROW_W;
  localparam int SCAN_ROWS_DEF = 32;
  localparam int PLANE_W       = 3;
  localparam int PC_W          = 4;
  localparam int BRT_W         = 6;
  localparam int DATA_W        = 32;
  localparam int CTRL_W        = 31;
  localparam int DELAY_W       = 13;
  localparam int BRTF_W        = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 6;

  localparam logic [PC_W-1:0]  PC_MIN    = PC_W'(4);
  localparam logic [PC_W-1:0]  PC_MAX    = PC_W'(8);
  localparam logic [PC_W-1:0]  PC_RESET  = PC_W'(8);
  localparam logic [BRT_W-1:0] BRT_RESET = '0;
  localparam logic [BRT_W-1:0] BRT_FULL  = BRT_W'(63);
  localparam int DELAY_BASE = 5;  // (1 << (p - 1)) << 6 == 1 << (p + 5)

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_CONVERT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_COUNT       = 1'b0,
    REG_MASTER_BRIGHTNESS = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [PC_W-1:0]  plane_count;
    logic [BRT_W-1:0] master_brightness;
  } cfg_t;

  // Row wrap table for a scan of n rows, built by counting.
  function automatic logic [ROW_SPAN-1:0][ROW_W-1:0] row_wrap_table(input int n);
    logic [ROW_SPAN-1:0][ROW_W-1:0] t;
    int c;
    c = 0;
    for (int i = 0; i < ROW_SPAN; i++) begin
      t[i] = ROW_W'(c);
      c = c + 1;
      if (c >= n) begin
        c = 0;
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lmbp_palette.sv]
`timescale 1ns / 1ps
`default_nettype none

// Overlay palette. One bank per column, each with two read ports (upper and
// lower pixel of that column); writes go to every bank.
module lmbp_palette import lmbp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [PAL_AW-1:0]           wr_addr,
  input  pix_t                        wr_data,
  input  logic                        rd_en,
  input  logic [COLS-1:0][PAL_AW-1:0] rd_addr_u,
  input  logic [COLS-1:0][PAL_AW-1:0] rd_addr_l,
  output pix_t [COLS-1:0]             rd_data_u,
  output pix_t [COLS-1:0]             rd_data_l,
  output logic [COLS-1:0]             rd_vld_u,
  output logic [COLS-1:0]             rd_vld_l
);

  // entry written since reset; unwritten entries give rd_vld low and the packer reads them as zero
  logic [PAL_DEPTH-1:0] vld_r;
  logic [PAL_DEPTH-1:0] vld_nxt;

  always_comb begin
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar b = 0; b < COLS; b++) begin : g_bank
    pix_t mem_r [PAL_DEPTH];
    pix_t rd_u_r;
    pix_t rd_l_r;
    logic vld_u_r;
    logic vld_l_r;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem_r[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_u_r  <= mem_r[rd_addr_u[b]];
        rd_l_r  <= mem_r[rd_addr_l[b]];
        vld_u_r <= vld_r[rd_addr_u[b]];
        vld_l_r <= vld_r[rd_addr_l[b]];
      end
    end

    assign rd_data_u[b] = rd_u_r;
    assign rd_data_l[b] = rd_l_r;
    assign rd_vld_u[b]  = vld_u_r;
    assign rd_vld_l[b]  = vld_l_r;
  end

endmodule

`default_nettype wire

[hw/rtl/lmbp_pack.sv]
`timescale 1ns / 1ps
`default_nettype none

// Overlay substitution, bit slicing and row control word.
module lmbp_pack import lmbp_pkg::*; #(
  parameter int SCAN_ROWS = SCAN_ROWS_DEF
) (
  input  cfg_t                      cfg,
  input  pix_t [COLS-1:0]           upper_pix,
  input  pix_t [COLS-1:0]           lower_pix,
  input  logic [COLS-1:0][OVL_W-1:0] upper_ovl,
  input  logic [COLS-1:0][OVL_W-1:0] lower_ovl,
  input  pix_t [COLS-1:0]           upper_pal,
  input  pix_t [COLS-1:0]           lower_pal,
  input  logic [COLS-1:0]           upper_pal_vld,
  input  logic [COLS-1:0]           lower_pal_vld,
  input  logic [PLANE_W-1:0]        plane,
  input  logic [ROW_W-1:0]          row,
  input  logic                      row_end,
  output logic [DATA_W-1:0]         data_word,
  output logic                      ctrl_valid,
  output logic [CTRL_W-1:0]         ctrl_word
);

  localparam logic [ROW_SPAN-1:0][ROW_W-1:0] ROW_TBL = row_wrap_table(SCAN_ROWS);

  logic [PC_W-1:0]    pc;
  logic [PLANE_W-1:0] p_max;
  logic [PLANE_W-1:0] p;
  logic [PLANE_W-1:0] bit_sel;
  logic [PLANE_W-1:0] brt_shift;
  logic [DELAY_W-1:0] delay;
  logic [BRTF_W-1:0]  brt;
  pix_t [COLS-1:0]    up_sel;
  pix_t [COLS-1:0]    lo_sel;

  always_comb begin
    if (cfg.plane_count < PC_MIN) begin
      pc = PC_MIN;
    end else if (cfg.plane_count > PC_MAX) begin
      pc = PC_MAX;
    end else begin
      pc = cfg.plane_count;
    end
    p_max   = PLANE_W'(pc - PC_W'(1));
    p       = (plane > p_max) ? p_max : plane;
    bit_sel = PLANE_W'({1'b0, p} + (PC_MAX - pc));
  end

  always_comb begin
    data_word = '0;
    for (int k = 0; k < COLS; k++) begin
      if (upper_ovl[k] != '0) begin
        up_sel[k] = upper_pal_vld[k] ? upper_pal[k] : '0;
      end else begin
        up_sel[k] = upper_pix[k];
      end
      if (lower_ovl[k] != '0) begin
        lo_sel[k] = lower_pal_vld[k] ? lower_pal[k] : '0;
      end else begin
        lo_sel[k] = lower_pix[k];
      end
      // channel c of the chosen plane sits at bit c*8 + bit_sel
      data_word[8*k +: 8] = {2'b00,
                             lo_sel[k][{2'd0, bit_sel}],
                             lo_sel[k][{2'd1, bit_sel}],
                             lo_sel[k][{2'd2, bit_sel}],
                             up_sel[k][{2'd0, bit_sel}],
                             up_sel[k][{2'd1, bit_sel}],
                             up_sel[k][{2'd2, bit_sel}]};
    end
  end

  always_comb begin
    brt_shift = (p == '0) ? '0 : PLANE_W'(p - PLANE_W'(1));
    delay     = (p == '0) ? '0 : (DELAY_W'(1) << (DELAY_W'(p) + DELAY_W'(DELAY_BASE)));
    brt       = BRTF_W'(BRT_FULL - cfg.master_brightness) << brt_shift;
    ctrl_valid = row_end;
    if (row_end) begin
      ctrl_word = {1'b0, brt, delay, ROW_TBL[row]};
    end else begin
      ctrl_word = '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/led_matrix_bitplane_packer.sv]
`timescale 1ns / 1ps
`default_nettype none

// LED matrix bit-plane packer.
// Input channel (in_valid/in_ready): a palette write (operation 0) stores
// palette_color into entry palette_index (index 0 ignored) and gives no
// result; a convert (operation 1) gives exactly one result on the out_
// channel: the 32-bit plane data word and, on row_end, the row control word.
// Config port: cfg_we writes plane_count (index 0) or master_brightness
// (index 1) from cfg_wdata; write only while the block is idle.
// Pipeline: an accepted convert is held in the palette read stage, then in
// the output register, where it waits for the out_ channel transfer.
// Throughput: one item per cycle while the receiver does not stall, set by
// the two-stage pipeline; palette writes take one input transfer each.
// Reset clears the pipeline, loads plane_count 8 and brightness 0 and marks
// every palette entry unwritten (reads as zero); no clearing sweep needed.
// When the receiver stalls, the output register holds its result, the read
// stage fills, and in_ready drops only once both stages hold a result.
module led_matrix_bitplane_packer import lmbp_pkg::*; #(
  parameter int SCAN_ROWS = SCAN_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [PAIR_W-1:0]     in_upper_pixels_01,
  input  logic [PAIR_W-1:0]     in_upper_pixels_23,
  input  logic [PAIR_W-1:0]     in_lower_pixels_01,
  input  logic [PAIR_W-1:0]     in_lower_pixels_23,
  input  logic [OVLS_W-1:0]     in_upper_overlays,
  input  logic [OVLS_W-1:0]     in_lower_overlays,
  input  logic [PLANE_W-1:0]    in_plane,
  input  logic [ROW_W-1:0]      in_row,
  input  logic                  in_row_end,
  input  logic [PAL_AW-1:0]     in_palette_index,
  input  logic [PIX_W-1:0]      in_palette_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     out_data_word,
  output logic                  out_ctrl_valid,
  output logic [CTRL_W-1:0]     out_ctrl_word
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PLANE_COUNT:       cfg_nxt.plane_count       = cfg_wdata[PC_W-1:0];
        REG_MASTER_BRIGHTNESS: cfg_nxt.master_brightness = cfg_wdata[BRT_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane_count       <= PC_RESET;
      cfg_r.master_brightness <= BRT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // handshake
  logic a_vld_r;
  logic a_vld_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic b_ready;
  logic a_adv;
  logic in_xfer;
  logic conv_xfer;
  logic pal_we;

  assign b_ready   = !out_valid_r || out_ready;
  assign a_adv     = a_vld_r && b_ready;
  assign in_ready  = !a_vld_r || b_ready;
  assign in_xfer   = in_valid && in_ready;
  assign conv_xfer = in_xfer && (in_operation == OP_CONVERT);
  assign pal_we    = in_xfer && (in_operation == OP_WRITE) && (in_palette_index != '0);

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (conv_xfer) begin
      a_vld_nxt = 1'b1;
    end else if (a_adv) begin
      a_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (a_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= a_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // read stage payload
  logic [PAIR_W-1:0]  a_up01_r;
  logic [PAIR_W-1:0]  a_up23_r;
  logic [PAIR_W-1:0]  a_lo01_r;
  logic [PAIR_W-1:0]  a_lo23_r;
  logic [OVLS_W-1:0]  a_up_ovl_r;
  logic [OVLS_W-1:0]  a_lo_ovl_r;
  logic [PLANE_W-1:0] a_plane_r;
  logic [ROW_W-1:0]   a_row_r;
  logic               a_row_end_r;

  always_ff @(posedge clk) begin
    if (conv_xfer) begin
      a_up01_r    <= in_upper_pixels_01;
      a_up23_r    <= in_upper_pixels_23;
      a_lo01_r    <= in_lower_pixels_01;
      a_lo23_r    <= in_lower_pixels_23;
      a_up_ovl_r  <= in_upper_overlays;
      a_lo_ovl_r  <= in_lower_overlays;
      a_plane_r   <= in_plane;
      a_row_r     <= in_row;
      a_row_end_r <= in_row_end;
    end
  end

  pix_t [COLS-1:0] pal_u;
  pix_t [COLS-1:0] pal_l;
  logic [COLS-1:0] pal_vld_u;
  logic [COLS-1:0] pal_vld_l;

  lmbp_palette u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (pal_we),
    .wr_addr   (in_palette_index),
    .wr_data   (in_palette_color),
    .rd_en     (conv_xfer),
    .rd_addr_u (in_upper_overlays),
    .rd_addr_l (in_lower_overlays),
    .rd_data_u (pal_u),
    .rd_data_l (pal_l),
    .rd_vld_u  (pal_vld_u),
    .rd_vld_l  (pal_vld_l)
  );

  logic [DATA_W-1:0] data_nxt;
  logic              ctrl_vld_nxt;
  logic [CTRL_W-1:0] ctrl_nxt;

  lmbp_pack #(
    .SCAN_ROWS (SCAN_ROWS)
  ) u_pack (
    .cfg           (cfg_r),
    .upper_pix     ({a_up23_r, a_up01_r}),
    .lower_pix     ({a_lo23_r, a_lo01_r}),
    .upper_ovl     (a_up_ovl_r),
    .lower_ovl     (a_lo_ovl_r),
    .upper_pal     (pal_u),
    .lower_pal     (pal_l),
    .upper_pal_vld (pal_vld_u),
    .lower_pal_vld (pal_vld_l),
    .plane         (a_plane_r),
    .row           (a_row_r),
    .row_end       (a_row_end_r),
    .data_word     (data_nxt),
    .ctrl_valid    (ctrl_vld_nxt),
    .ctrl_word     (ctrl_nxt)
  );

  logic [DATA_W-1:0] out_data_r;
  logic              out_ctrl_vld_r;
  logic [CTRL_W-1:0] out_ctrl_r;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_data_r     <= data_nxt;
      out_ctrl_vld_r <= ctrl_vld_nxt;
      out_ctrl_r     <= ctrl_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_word  = out_data_r;
  assign out_ctrl_valid = out_ctrl_vld_r;
  assign out_ctrl_word  = out_ctrl_r;

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid && !a_vld_r)
    else $error("pipeline not empty after reset");

  a_conv_loads : assert property (@(posedge clk) disable iff (!rst_n)
    conv_xfer |=> a_vld_r)
    else $error("convert transfer lost in read stage");

  a_write_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_operation == OP_WRITE) && !a_vld_r |=> !a_vld_r)
    else $error("palette write produced a result");

  a_ctrl_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ctrl_valid |-> out_ctrl_word == '0)
    else $error("control word set without row end");

  a_row_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ctrl_valid |-> int'(out_ctrl_word[ROW_W-1:0]) < SCAN_ROWS)
    else $error("row address beyond scan");

endmodule

`default_nettype wire
